// ===== design/aima_pkg.sv =====
`default_nettype none
package aima_pkg;

  localparam logic [1:0] MODE_FILE_HDR  = 2'd0;
  localparam logic [1:0] MODE_CHUNK_HDR = 2'd1;
  localparam logic [1:0] MODE_DATA      = 2'd2;
  localparam logic [1:0] MODE_SCAN      = 2'd3;

  localparam int WINDOW_DEPTH = 12;
  localparam logic [6:0] MAX_INDEX = 7'd88;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_hdr;    // take rate, predictor and index from the window
    logic       emit_init;   // present the header sample
    logic       dec_nib;     // decode one nibble
    logic [1:0] byte_sel;    // window byte to decode (0..3 = bytes 8..11)
    logic       hi_nib;      // upper nibble of that byte
  } dp_cmd_t;

  // Step size for a step index
  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] s;
    case (idx)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
      7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
      7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
      7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
      7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
      7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
      7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
      7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
      7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
      7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
      7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
      7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
      7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;  7'd88: s = 15'd32767;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Index adjustment for the magnitude bits of a nibble
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4: a = 5'sd2;
      3'd5: a = 5'sd4;
      3'd6: a = 5'sd6;
      3'd7: a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== design/aud_ima_adpcm_stream_decoder_unit.sv =====
// A byte is shifted into the window and evaluated, and any samples it yields are
// decoded and held for the sink one at a time; a sink stall holds the output.
// A new byte is taken only once the last one and all its samples are through.
// When a chunk opens, held data bytes in the window are replayed. rst (synchronous,
// active high) returns to file-header mode with all state cleared.
`default_nettype none
module aud_ima_adpcm_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // file_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pcm_sample [15:0], rate [31:16]
  output logic             m_axis_tlast    // last_of_run
);

  aima_pkg::dp_cmd_t  cmd;
  logic [7:0]         win [aima_pkg::WINDOW_DEPTH];
  logic signed [15:0] sample;
  logic [15:0]        rate;

  aima_control u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_end(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_last(m_axis_tlast),
    .cmd(cmd), .win(win)
  );

  aima_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .win(win), .sample(sample), .rate(rate)
  );

  assign m_axis_tdata = {rate, sample};

endmodule
`default_nettype wire

// ===== design/aima_datapath.sv =====
`default_nettype none
module aima_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire aima_pkg::dp_cmd_t    cmd,
  input  wire logic [7:0]           win [aima_pkg::WINDOW_DEPTH],
  output logic signed [15:0]        sample,
  output logic [15:0]               rate
);

  logic signed [15:0] predictor;
  logic [6:0]         step_index;
  logic [7:0]         cur_byte;
  logic [3:0]         nib;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] predictor_next;
  logic signed [7:0]  idx_sum;
  logic [6:0]         step_index_next;

  // Select the byte and nibble to decode
  always_comb begin
    cur_byte = win[4'd8 + {2'b00, cmd.byte_sel}];
    nib      = cmd.hi_nib ? cur_byte[7:4] : cur_byte[3:0];
  end

  // One nibble update: difference, saturate, adapt index
  always_comb begin
    step = aima_pkg::step_lookup(step_index);
    diff = {5'd0, step[14:3]};
    if (nib[0]) diff = diff + {4'd0, step[14:2]};
    if (nib[1]) diff = diff + {3'd0, step[14:1]};
    if (nib[2]) diff = diff + {2'd0, step};
    if (nib[3]) sum = $signed({{2{predictor[15]}}, predictor}) - $signed({1'b0, diff});
    else        sum = $signed({{2{predictor[15]}}, predictor}) + $signed({1'b0, diff});
    if (sum > 18'sd32767)       predictor_next = 16'sh7FFF;
    else if (sum < -18'sd32768) predictor_next = -16'sh8000;
    else                        predictor_next = sum[15:0];
    idx_sum = $signed({1'b0, step_index}) + 8'(aima_pkg::index_adjust(nib[2:0]));
    if (idx_sum < 8'sd0)                                step_index_next = 7'd0;
    else if (idx_sum > $signed({1'b0, aima_pkg::MAX_INDEX})) step_index_next = aima_pkg::MAX_INDEX;
    else                                                step_index_next = idx_sum[6:0];
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= 16'd0;
      predictor  <= 16'sd0;
      step_index <= 7'd0;
      sample     <= 16'sd0;
    end else begin
      if (cmd.load_hdr) begin
        rate       <= {win[1], win[0]};
        predictor  <= {win[7], win[6]};
        step_index <= (win[8] > {1'b0, aima_pkg::MAX_INDEX}) ? aima_pkg::MAX_INDEX
                                                               : win[8][6:0];
      end else if (cmd.dec_nib) begin
        predictor  <= predictor_next;
        step_index <= step_index_next;
      end
      if (cmd.emit_init) sample <= {win[7], win[6]};
      else if (cmd.dec_nib) sample <= predictor_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/aima_control.sv =====
`default_nettype none
module aima_control (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_last,
  output aima_pkg::dp_cmd_t       cmd,
  output logic [7:0]              win [aima_pkg::WINDOW_DEPTH]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;  // act on the shifted window
  localparam logic [2:0] ST_INIT  = 3'd2;  // load header values
  localparam logic [2:0] ST_START = 3'd3;  // open a chunk at header offset hdr
  localparam logic [2:0] ST_DEC   = 3'd4;  // decode one nibble
  localparam logic [2:0] ST_OUT   = 3'd5;  // result held for the sink
  localparam logic [2:0] ST_FIN   = 3'd6;  // apply end-of-file

  logic [2:0]  state;
  logic [1:0]  mode;
  logic [3:0]  pos;
  logic [15:0] left;
  logic [1:0]  cur;      // byte being decoded, 0..3 = window 8..11
  logic        hi;
  logic        ending;
  logic [2:0]  hdr;      // chunk header start h, 0..4
  logic        more;     // another nibble follows the one on the output

  logic [4:0]  mk_at;    // marker at window offsets 4..8
  logic        hit;
  logic [2:0]  hit_hdr;
  logic [15:0] sz;
  logic [15:0] left_after;
  logic        more_bytes;

  function automatic logic is_marker(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3);
    return b0 == 8'hAF && b1 == 8'hDE && b2 == 8'h00 && b3 == 8'h00;
  endfunction

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load_hdr  = (state == ST_INIT);
    cmd.emit_init = (state == ST_INIT);
    cmd.dec_nib   = (state == ST_DEC);
    cmd.byte_sel  = cur;
    cmd.hi_nib    = hi;
  end

  // Look for the marker, the one in place first, then the earliest
  always_comb begin
    mk_at[0] = is_marker(win[4], win[5], win[6], win[7]);
    mk_at[1] = is_marker(win[5], win[6], win[7], win[8]);
    mk_at[2] = is_marker(win[6], win[7], win[8], win[9]);
    mk_at[3] = is_marker(win[7], win[8], win[9], win[10]);
    mk_at[4] = is_marker(win[8], win[9], win[10], win[11]);
    hit = |mk_at;
    if (mk_at[4])      hit_hdr = 3'd4;
    else if (mk_at[0]) hit_hdr = 3'd0;
    else if (mk_at[1]) hit_hdr = 3'd1;
    else if (mk_at[2]) hit_hdr = 3'd2;
    else               hit_hdr = 3'd3;
  end

  // Chunk size at the header offset, and the byte walk of a replay
  always_comb begin
    sz         = {win[{1'b0, hdr} + 4'd1], win[{1'b0, hdr}]};
    left_after = left - 16'd1;
    more_bytes = (left_after != 16'd0) && (cur != 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= aima_pkg::MODE_FILE_HDR;
      pos   <= 4'd0;
      left  <= 16'd0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      cur <= 2'd0; hi <= 1'b0; ending <= 1'b0; hdr <= 3'd0; more <= 1'b0;
      for (int i = 0; i < 12; i++) win[i] <= 8'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          // Shift the beat into the window
          if (in_valid) begin
            for (int i = 0; i < 11; i++) win[i] <= win[i+1];
            win[11] <= in_byte;
            ending  <= in_end;
            state   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          unique case (mode)
            aima_pkg::MODE_FILE_HDR: begin
              if (pos >= 4'd11) begin
                pos   <= 4'd0;
                mode  <= aima_pkg::MODE_CHUNK_HDR;
                state <= ST_INIT;
              end else begin
                pos   <= pos + 4'd1;
                state <= ST_FIN;
              end
            end
            aima_pkg::MODE_CHUNK_HDR: begin
              pos <= pos + 4'd1;
              if (pos >= 4'd7 && hit) begin
                hdr   <= hit_hdr;
                state <= ST_START;
              end else begin
                if (pos >= 4'd7) mode <= aima_pkg::MODE_SCAN;
                state <= ST_FIN;
              end
            end
            aima_pkg::MODE_DATA: begin
              cur <= 2'd3; hi <= 1'b0; state <= ST_DEC;
            end
            aima_pkg::MODE_SCAN: begin
              if (mk_at[4]) begin
                hdr   <= 3'd4;
                state <= ST_START;
              end else state <= ST_FIN;
            end
          endcase
        end
        ST_INIT: begin
          out_valid <= 1'b1;
          out_last  <= 1'b1;
          more      <= 1'b0;
          state     <= ST_OUT;
        end
        ST_START: begin
          // Open the chunk; replay held data bytes when there are any
          left <= sz;
          if (hdr == 3'd4 || sz == 16'd0) begin
            pos   <= 4'd4 - {1'b0, hdr};
            mode  <= (sz != 16'd0) ? aima_pkg::MODE_DATA : aima_pkg::MODE_CHUNK_HDR;
            state <= ST_FIN;
          end else begin
            pos   <= 4'd0;
            cur   <= hdr[1:0];
            hi    <= 1'b0;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          out_valid <= 1'b1;
          state     <= ST_OUT;
          if (!hi) begin
            out_last <= 1'b0; more <= 1'b1;
          end else if (mode == aima_pkg::MODE_DATA) begin
            out_last <= 1'b1; more <= 1'b0;
            left     <= left_after;
            if (left_after == 16'd0) begin
              mode <= aima_pkg::MODE_CHUNK_HDR; pos <= 4'd0;
            end
          end else begin
            // replay of held bytes after a chunk start
            left <= left_after;
            if (more_bytes) begin
              out_last <= 1'b0; more <= 1'b1;
            end else begin
              out_last <= 1'b1; more <= 1'b0;
              pos  <= (left_after == 16'd0) ? {2'b00, 2'd3 - cur} : 4'd0;
              mode <= (left_after != 16'd0) ? aima_pkg::MODE_DATA
                                            : aima_pkg::MODE_CHUNK_HDR;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (more) begin
              state <= ST_DEC;
              if (!hi) hi <= 1'b1;
              else begin
                hi  <= 1'b0;
                cur <= cur + 2'd1;
              end
            end else state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          if (ending) begin
            mode <= aima_pkg::MODE_FILE_HDR; pos <= 4'd0; left <= 16'd0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] dat;
    logic       fend;
    bit         known;  // expected sample typed in
    logic [15:0] want;
  } byte_row_t;

  typedef struct {
    logic [15:0] pcm;
    logic [15:0] rate;
    logic        tl;
  } pcm_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;  // data_byte
  logic s_axis_tlast = 1'b0;        // file_end
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // pcm_sample [15:0], rate [31:16]
  logic m_axis_tlast;               // last_of_run

  aud_ima_adpcm_stream_decoder_unit dut (.*);

  always #5 clk = ~clk;

  // Decoder mirror
  logic [1:0]  pmode;
  logic [3:0]  bpos;
  logic [7:0]  win [12];
  logic [15:0] left;
  int          pred, sidx;
  logic [15:0] rate;
  int          n_new;

  pcm_beat_t pcm_q[$];
  byte_row_t rows[$];
  int errors = 0, n_bytes = 0, n_samples = 0, cyc = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_sample(int s);
    pcm_beat_t b;
    if (n_new >= 8) return;
    b.pcm = s[15:0];
    b.rate = rate;
    b.tl = 1'b0;
    pcm_q = {pcm_q, b};
    n_new++;
  endfunction

  function automatic void nibble_decode(logic [3:0] n);
    int step, diff;
    step = aima_pkg::step_lookup(sidx[6:0]);
    diff = step >> 3;
    if (n[0]) diff += step >> 2;
    if (n[1]) diff += step >> 1;
    if (n[2]) diff += step;
    pred += n[3] ? -diff : diff;
    if (pred > 32767) pred = 32767;
    if (pred < -32768) pred = -32768;
    sidx += aima_pkg::index_adjust(n[2:0]);
    if (sidx < 0) sidx = 0;
    if (sidx > 88) sidx = 88;
    push_sample(pred);
  endfunction

  function automatic bit marker_at(int i);
    return win[i] == 8'hAF && win[i+1] == 8'hDE && win[i+2] == 8'h00 && win[i+3] == 8'h00;
  endfunction

  function automatic void chunk_open(int h);
    left = {win[h+1], win[h]};
    bpos = 0;
    for (int i = h + 8; i < 12; i++) begin
      if (left != 0) begin
        nibble_decode(win[i][3:0]);
        nibble_decode(win[i][7:4]);
        left--;
      end else bpos++;
    end
    pmode = (left != 0) ? aima_pkg::MODE_DATA : aima_pkg::MODE_CHUNK_HDR;
  endfunction

  // Advance the mirror by one byte, queue its samples
  function automatic void decode_byte_in(logic [7:0] b, logic fend);
    n_new = 0;
    for (int i = 0; i < 11; i++) win[i] = win[i+1];
    win[11] = b;
    case (pmode)
      aima_pkg::MODE_FILE_HDR: begin
        bpos++;
        if (bpos >= 12) begin
          rate = {win[1], win[0]};
          pred = $signed({win[7], win[6]});
          sidx = (win[8] > 88) ? 88 : win[8];
          push_sample(pred);
          pmode = aima_pkg::MODE_CHUNK_HDR;
          bpos = 0;
        end
      end
      aima_pkg::MODE_CHUNK_HDR: begin
        bpos++;
        if (bpos >= 8) begin
          if (marker_at(8)) chunk_open(4);
          else begin
            pmode = aima_pkg::MODE_SCAN;
            for (int o = 0; o < 4; o++)
              if (marker_at(4 + o)) begin
                chunk_open(o);
                break;
              end
          end
        end
      end
      aima_pkg::MODE_DATA: begin
        nibble_decode(b[3:0]);
        nibble_decode(b[7:4]);
        if (left != 0) left--;
        if (left == 0) begin
          pmode = aima_pkg::MODE_CHUNK_HDR;
          bpos = 0;
        end
      end
      default: if (marker_at(8)) chunk_open(4);
    endcase
    if (fend) begin
      pmode = aima_pkg::MODE_FILE_HDR;
      bpos = 0;
      left = 0;
    end
    if (n_new > 0) pcm_q[$].tl = 1'b1;
  endfunction

  task automatic add(input logic [7:0] d, input logic f = 1'b0,
                     input bit k = 0, input logic [15:0] w = 16'd0);
    byte_row_t r;
    r.dat = d; r.fend = f; r.known = k; r.want = w;
    rows = {rows, r};
  endtask

  task automatic add_hdr(input logic [15:0] rt, input logic [15:0] init, input logic [7:0] ix,
                         input bit typed);
    add(rt[7:0]); add(rt[15:8]);
    repeat (4) add(8'($urandom));
    add(init[7:0]); add(init[15:8]); add(ix);
    add(8'($urandom)); add(8'($urandom));
    add(8'($urandom), 1'b0, typed, init);
  endtask

  task automatic add_chunk_hdr(input logic [15:0] sz);
    add(sz[7:0]); add(sz[15:8]); add(8'($urandom)); add(8'($urandom));
    add(8'hAF); add(8'hDE); add(8'h00); add(8'h00);
  endtask

  // Send one byte and queue its expected samples
  task automatic send_byte(input byte_row_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= r.dat;
    s_axis_tlast <= r.fend;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_byte_in(r.dat, r.fend);
    if (r.known && (n_new != 1 || pcm_q[$].pcm !== r.want)) begin
      $display("%0t: table row mismatch, expected sample %h, actual %0d samples, last %h",
               $realtime, r.want, n_new, (n_new > 0) ? pcm_q[$].pcm : 16'h0000);
      errors++;
    end
    n_bytes++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pcm_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random files: mostly well-formed, some noise
  task automatic build_random_file();
    int nch, sz;
    add_hdr(16'($urandom), 16'($urandom), 8'($urandom_range(0, 120)), 0);
    nch = $urandom_range(1, 3);
    for (int c = 0; c < nch; c++) begin
      sz = $urandom_range(0, 12);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 6)) add(8'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        add(8'hAF); add(8'hDE); add(8'h00); add(8'h00);
      end else add_chunk_hdr(16'(sz));
      for (int i = 0; i < sz; i++) add(8'($urandom));
    end
    rows[$].fend = 1'b1;
  endtask

  // Sink with random stalls, mostly short and a few long
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tready && m_axis_tvalid) begin
        if (pcm_q.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          pcm_beat_t e;
          e = pcm_q.pop_front();
          n_samples++;
          if (m_axis_tdata[15:0] !== e.pcm || m_axis_tdata[31:16] !== e.rate ||
              m_axis_tlast !== e.tl) begin
            $display("%0t: mismatch expected pcm %h rate %h last %b, actual %h %h %b",
                     $realtime, e.pcm, e.rate, e.tl, m_axis_tdata[15:0],
                     m_axis_tdata[31:16], m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        hold = gap_len();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    pmode = aima_pkg::MODE_FILE_HDR; bpos = 0; left = 0; pred = 0; sidx = 0; rate = 0;
    foreach (win[i]) win[i] = 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme header, saturating data, empty chunk, file end inside a
    // chunk, short file
    add_hdr(16'hFFFF, 16'h7FFF, 8'hFF, 1);
    add_chunk_hdr(16'd2);
    add(8'h77); add(8'h77);
    add_chunk_hdr(16'd0);
    add(8'h05); add(8'h00); add(8'h12); add(8'h34);
    add(8'hAF); add(8'hDE); add(8'h00); add(8'h00);
    add(8'hFF); add(8'h88); add(8'h00); add(8'hF0, 1'b1);
    add_hdr(16'h0000, 16'h8000, 8'h00, 1);
    add(8'h03); add(8'h00, 1'b1);
    foreach (rows[i]) send_byte(rows[i]);
    rows.delete();
    drain();

    while (n_bytes < 220) begin
      build_random_file();
      foreach (rows[i]) send_byte(rows[i]);
      rows.delete();
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();

    $display("tb: %0d bytes sent, %0d samples checked over headers, chunks and resyncs",
             n_bytes, n_samples);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/aima_pkg.sv
design/aima_datapath.sv
design/aima_control.sv
design/aud_ima_adpcm_stream_decoder_unit.sv
tb/tb.sv
